// File: src/sha_pkg.sv
// Package for the SHA-256 block hasher: shared types, round constants, functions.
// No dependencies; used by all modules through scoped names.
package sha_pkg;

    localparam int WordW  = 32;
    localparam int Rounds = 64;
    localparam int QDepth = 2;

    typedef logic [WordW-1:0] t_word;

    // Block handed from the front part to the compression engine.
    typedef struct packed {
        logic [16*WordW-1:0] words;   // word 0 in the top bits
        logic                eom;
    } t_block;

    localparam logic [31:0] RoundK [Rounds] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] InitHash [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic t_word rotr(input t_word x, input int n);
        rotr = (x >> n) | (x << (WordW - n));
    endfunction

endpackage

// File: src/sha_front.sv
// Front part: collects sixteen message words into a block and queues it.
// Depends on sha_pkg.
module sha_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  sha_pkg::t_word       i_message_word,
    input  logic                 i_end_of_message,
    output logic                 o_blk_valid,
    input  logic                 i_blk_take,
    output sha_pkg::t_block      o_blk
);

    logic [3:0]                  r_pos;
    logic [15*sha_pkg::WordW-1:0] r_shift;
    sha_pkg::t_block             r_q [sha_pkg::QDepth];
    logic                        r_wp, r_rp;
    logic [1:0]                  r_cnt;
    logic                        w_acc, w_push;

    assign o_stall = (r_pos == 4'd15) && (r_cnt == 2'(sha_pkg::QDepth));
    assign w_acc   = i_valid && !o_stall;
    assign w_push  = w_acc && (r_pos == 4'd15);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (w_acc) r_pos <= r_pos + 4'd1;
            if (w_push) r_wp <= ~r_wp;
            if (i_blk_take) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_blk_take};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc)
            r_shift <= {r_shift[14*sha_pkg::WordW-1:0], i_message_word};
        if (w_push)
            r_q[r_wp] <= '{words: {r_shift, i_message_word}, eom: i_end_of_message};
    end

    assign o_blk_valid = (r_cnt != 2'd0);
    assign o_blk       = r_q[r_rp];

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'(sha_pkg::QDepth))
        else $error("queue overfilled");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_blk_take |-> o_blk_valid)
        else $error("take from empty queue");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |=> r_pos == 4'd0)
        else $error("position not wrapped");

endmodule

// File: src/sha_core.sv
// Back part: 64-round compression, one round a cycle, and digest output.
// Depends on sha_pkg.
module sha_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_blk_valid,
    output logic                 o_blk_take,
    input  sha_pkg::t_block      i_blk,
    output logic                 o_valid,
    input  logic                 i_stall,
    output sha_pkg::t_word       o_digest_word,
    output logic [2:0]           o_word_index,
    output logic                 o_last_word
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001, S_RUN = 4'b0010, S_ADD = 4'b0100, S_OUT = 4'b1000
    } t_state;

    t_state          r_state, n_state;
    logic [5:0]      r_rnd;
    logic [2:0]      r_oidx;
    logic            r_eom;
    sha_pkg::t_word  r_w [16];
    sha_pkg::t_word  r_v [8];
    sha_pkg::t_word  r_h [8];
    sha_pkg::t_word  w_s0, w_s1, w_new, w_t1, w_t2, w_ch, w_maj, w_b0, w_b1;

    always_comb begin
        w_s0  = sha_pkg::rotr(r_w[1], 7) ^ sha_pkg::rotr(r_w[1], 18) ^ (r_w[1] >> 3);
        w_s1  = sha_pkg::rotr(r_w[14], 17) ^ sha_pkg::rotr(r_w[14], 19) ^ (r_w[14] >> 10);
        w_new = w_s1 + r_w[9] + w_s0 + r_w[0];
        w_ch  = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        w_maj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        w_b1  = sha_pkg::rotr(r_v[4], 6) ^ sha_pkg::rotr(r_v[4], 11)
              ^ sha_pkg::rotr(r_v[4], 25);
        w_b0  = sha_pkg::rotr(r_v[0], 2) ^ sha_pkg::rotr(r_v[0], 13)
              ^ sha_pkg::rotr(r_v[0], 22);
        w_t1  = r_v[7] + w_b1 + w_ch + sha_pkg::RoundK[r_rnd] + r_w[0];
        w_t2  = w_b0 + w_maj;
    end

    assign o_blk_take = (r_state == S_IDLE) && i_blk_valid;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_blk_valid) n_state = S_RUN;
            S_RUN:   if (r_rnd == 6'd63) n_state = S_ADD;
            S_ADD:   n_state = r_eom ? S_OUT : S_IDLE;
            S_OUT:   if (!i_stall && r_oidx == 3'd7) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rnd   <= '0;
            r_oidx  <= '0;
            for (int i = 0; i < 8; i++) r_h[i] <= sha_pkg::InitHash[i];
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: r_rnd <= '0;
                S_RUN:  r_rnd <= r_rnd + 6'd1;
                S_ADD: begin
                    for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
                    r_oidx <= '0;
                end
                S_OUT: if (!i_stall) begin
                    r_oidx <= r_oidx + 3'd1;
                    if (r_oidx == 3'd7)
                        for (int i = 0; i < 8; i++) r_h[i] <= sha_pkg::InitHash[i];
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_blk_take) begin
            for (int i = 0; i < 16; i++)
                r_w[i] <= i_blk.words[(15-i)*sha_pkg::WordW +: sha_pkg::WordW];
            for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
            r_eom <= i_blk.eom;
        end else if (r_state == S_RUN) begin
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
            r_w[15] <= w_new;
            r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + w_t1;
            r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
            r_v[0] <= w_t1 + w_t2;
        end
    end

    assign o_valid       = (r_state == S_OUT);
    assign o_digest_word = r_h[r_oidx];
    assign o_word_index  = r_oidx;
    assign o_last_word   = (r_oidx == 3'd7);

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("state not one-hot");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN && r_rnd == 6'd63) |=> r_state == S_ADD)
        else $error("round count broken");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_last_word) |=> r_h[0] == sha_pkg::InitHash[0])
        else $error("chain not reinitialized");

endmodule

// File: src/sha256_block_hasher.sv
// SHA-256 block hasher top level: front word collector, two-block queue,
// compression core. A block enters the queue when its 16th word is accepted;
// the core takes it while idle, runs one round per cycle, then adds into the
// chain and, on a message's final block, offers the eight digest words.
// Synchronous active-low reset restores the initial hash and empties the queue.
// Depends on sha_pkg, sha_front, sha_core.
module sha256_block_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_message_word,
    input  logic        i_end_of_message,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    // Blocks travel from the collector to the core through a short queue.
    logic            w_blk_valid, w_blk_take;
    sha_pkg::t_block w_blk;

    sha_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_message_word, .i_end_of_message,
        .o_blk_valid(w_blk_valid), .i_blk_take(w_blk_take), .o_blk(w_blk)
    );

    // The core runs the 64 rounds and holds each digest word until taken.
    sha_core u_core (
        .i_clk, .i_rst_n, .i_blk_valid(w_blk_valid), .o_blk_take(w_blk_take),
        .i_blk(w_blk), .o_valid, .i_stall, .o_digest_word, .o_word_index, .o_last_word
    );

endmodule

// File: dv/sha256_block_hasher_test.sv
// Self-checking testbench for sha256_block_hasher: feeds random and padded words,
// predicts SHA-256 digests with its own compression model, checks each digest word.
// Depends on sha_pkg (word type) and the sha256_block_hasher RTL.
module sha256_block_hasher_test;
    timeunit 1ns;
    timeprecision 1ps;

    // One digest word as it leaves the block.
    typedef struct {
        sha_pkg::t_word digest;
        logic [2:0]     index;
        logic           last;
    } t_digest_item;

    // Scoreboard: keeps a private SHA-256 state, turns each accepted block that ends
    // a message into expected digest words, and checks the block's output against them.
    class digest_scoreboard;
        sha_pkg::t_word chain [8];
        sha_pkg::t_word words [16];
        int unsigned    position;
        t_digest_item   pending [$];
        int unsigned    errors;

        function new();
            errors = 0;
            reset_state();
        endfunction

        function void reset_state();
            foreach (chain[i]) chain[i] = sha_pkg::InitHash[i];
            foreach (words[i]) words[i] = '0;
            position = 0;
        endfunction

        function sha_pkg::t_word ror(sha_pkg::t_word x, int n);
            return (x >> n) | (x << (32 - n));
        endfunction

        function void compress();
            sha_pkg::t_word w [64];
            sha_pkg::t_word v [8];
            sha_pkg::t_word s0, s1, ch, maj, t1, t2;
            for (int t = 0; t < 16; t++) w[t] = words[t];
            for (int t = 16; t < 64; t++) begin
                s0 = ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3);
                s1 = ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10);
                w[t] = s1 + w[t-7] + s0 + w[t-16];
            end
            v = chain;
            for (int t = 0; t < 64; t++) begin
                ch  = (v[4] & v[5]) ^ (~v[4] & v[6]);
                maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
                t1  = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
                      + ch + sha_pkg::RoundK[t] + w[t];
                t2  = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22)) + maj;
                v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
                v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
            end
            for (int i = 0; i < 8; i++) chain[i] += v[i];
        endfunction

        // Note an accepted input item.
        function void note_word(sha_pkg::t_word word, logic eom);
            t_digest_item d;
            int unsigned  pos;
            pos = position;
            words[pos] = word;
            position = (pos + 1) % 16;
            if (pos != 15) return;
            compress();
            if (!eom) return;
            for (int i = 0; i < 8; i++) begin
                d.digest = chain[i];
                d.index  = 3'(i);
                d.last   = (i == 7);
                pending.push_back(d);
            end
            foreach (chain[i]) chain[i] = sha_pkg::InitHash[i];
        endfunction

        // Check one accepted result against the oldest expectation.
        function void check_digest(sha_pkg::t_word digest, logic [2:0] index, logic last);
            t_digest_item e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected digest word %h idx %0d last %0b",
                         $time, digest, index, last);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (digest !== e.digest) begin
                $display("%0t: digest_word expected %h actual %h",
                         $time, e.digest, digest);
                errors++;
            end
            if (index !== e.index) begin
                $display("%0t: word_index expected %0d actual %0d",
                         $time, e.index, index);
                errors++;
            end
            if (last !== e.last) begin
                $display("%0t: last_word expected %0b actual %0b",
                         $time, e.last, last);
                errors++;
            end
        endfunction
    endclass

    localparam int IdleCycleLimit = 5000;
    localparam int DrainCycles    = 100;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [31:0] i_message_word = '0;
    logic        i_end_of_message = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_index;
    logic        o_last_word;

    digest_scoreboard board = new();

    // Idle percentages for each side; the stimulus process sets them per phase.
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    bit          hold_off = 1'b0;
    int unsigned quiet_cycles = 0;
    int unsigned words_sent = 0;

    sha256_block_hasher DUT (.*);

    always #5 i_clk = ~i_clk;

    // Check results and count cycles with no progress at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall)
                board.check_digest(o_digest_word, o_word_index, o_last_word);
            if ((o_valid && !i_stall) || (i_valid && !o_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= IdleCycleLimit) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Receiver: stall at random, or hold off entirely when asked.
    always @(negedge i_clk) begin
        if (hold_off)
            i_stall <= 1'b1;
        else
            i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Offer one item and hold it until accepted; idle first at random.
    // Valid stays high after acceptance until the next item or an idle cycle.
    task automatic send_word(sha_pkg::t_word word, logic eom);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid          <= 1'b1;
        i_message_word   <= word;
        i_end_of_message <= eom;
        do @(posedge i_clk); while (o_stall);
        board.note_word(word, eom);
        words_sent++;
        @(negedge i_clk);
    endtask

    // Send one 16-word block; the end mark honored on the last word only.
    task automatic send_block(bit final_block, bit random_mid_eom);
        for (int i = 0; i < 16; i++)
            send_word($urandom(), (i == 15) ? final_block
                                            : (random_mid_eom && $urandom_range(1)));
    endtask

    // Drop valid, then wait until every expected digest word has come.
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (board.pending.size() != 0) @(negedge i_clk);
    endtask

    initial begin
        // Hold reset, then release at a falling edge.
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Pressure: receiver holds off while the sender keeps offering blocks.
        // The core waits on the first digest, two blocks fill the queue and
        // the fourth block's last word stalls the input.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off = 1'b1;
        fork
            begin
                repeat (600) @(negedge i_clk);
                hold_off = 1'b0;
            end
            for (int b = 0; b < 4; b++) send_block(1'b1, b == 1);
        join

        // Sender pauses until all results are in.
        wait_drained();

        // Two-block message with mid-block end marks, sender idling.
        send_idle_pct  = 66;
        recv_stall_pct = 0;
        send_block(1'b0, 1'b1);

        // Receiver stalling.
        send_idle_pct  = 0;
        recv_stall_pct = 66;
        send_block(1'b1, 1'b0);

        // Both idling: standard "abc" message.
        send_idle_pct  = 21;
        recv_stall_pct = 21;
        send_word(32'h6162_6380, 1'b0);
        for (int i = 1; i < 15; i++) send_word(32'h0, 1'b0);
        send_word(32'h0000_0018, 1'b1);

        wait_drained();
        repeat (DrainCycles) @(negedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
